// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, off while in reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/yrc_pkg.sv =====
package yrc_pkg;

  localparam int SUM_W = 27;

  localparam logic signed [SUM_W-1:0] COEF_RV = SUM_W'(89831);
  localparam logic signed [SUM_W-1:0] COEF_GV = SUM_W'(45744);
  localparam logic signed [SUM_W-1:0] COEF_GU = SUM_W'(22127);
  localparam logic signed [SUM_W-1:0] COEF_BU = SUM_W'(113538);
  localparam logic signed [8:0]       CHROMA_OFFSET = 9'sd128;
  localparam logic [9:0]              CLAMP_MAX = 10'd255;
  localparam logic [15:0]             SCALE_NUM = 16'd220;
  localparam logic [7:0]              CHAN_MAX = 8'd220;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end_in;
  } yrc_in_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       frame_end_out;
  } yrc_out_t;

  typedef struct packed {
    logic [7:0]              luma_first;
    logic [7:0]              luma_second;
    logic signed [SUM_W-1:0] prod_rv;
    logic signed [SUM_W-1:0] prod_gv;
    logic signed [SUM_W-1:0] prod_gu;
    logic signed [SUM_W-1:0] prod_bu;
    logic                    frame_end;
  } yrc_chroma_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } yrc_rgb_t;

  function automatic logic [7:0] finish_channel(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-18:0] whole;
    logic [7:0]        clamped;
    logic [15:0]       scaled;
    whole   = sum[SUM_W-2:16];
    clamped = (whole > CLAMP_MAX) ? CLAMP_MAX[7:0] : whole[7:0];
    scaled  = {8'h00, clamped} * SCALE_NUM;
    return sum[SUM_W-1] ? 8'h00 : scaled[15:8];
  endfunction

endpackage

// ===== hdl/yrc_chroma.sv =====
module yrc_chroma (
  input  logic                 clk,
  input  logic                 en,
  input  yrc_pkg::yrc_in_t     in_data,
  output yrc_pkg::yrc_chroma_t chroma
);
  import yrc_pkg::*;

  logic signed [8:0]       du;
  logic signed [8:0]       dv;
  logic signed [SUM_W-1:0] du_ext;
  logic signed [SUM_W-1:0] dv_ext;
  yrc_chroma_t             chroma_r;
  yrc_chroma_t             chroma_nxt;

  always_comb begin
    du     = $signed({1'b0, in_data.chroma_blue}) - CHROMA_OFFSET;
    dv     = $signed({1'b0, in_data.chroma_red}) - CHROMA_OFFSET;
    du_ext = SUM_W'(du);
    dv_ext = SUM_W'(dv);
    chroma_nxt.luma_first  = in_data.luma_first;
    chroma_nxt.luma_second = in_data.luma_second;
    chroma_nxt.prod_rv     = COEF_RV * dv_ext;
    chroma_nxt.prod_gv     = COEF_GV * dv_ext;
    chroma_nxt.prod_gu     = COEF_GU * du_ext;
    chroma_nxt.prod_bu     = COEF_BU * du_ext;
    chroma_nxt.frame_end   = in_data.frame_end_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chroma_r <= chroma_nxt;
    end
  end

  assign chroma = chroma_r;

endmodule

// ===== hdl/yrc_lane.sv =====
module yrc_lane (
  input  logic                    clk,
  input  logic                    en,
  input  logic [7:0]              luma,
  input  yrc_pkg::yrc_chroma_t    chroma,
  output yrc_pkg::yrc_rgb_t       pixel
);
  import yrc_pkg::*;

  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum_r_r;
  logic signed [SUM_W-1:0] sum_g_r;
  logic signed [SUM_W-1:0] sum_b_r;
  logic signed [SUM_W-1:0] sum_r_nxt;
  logic signed [SUM_W-1:0] sum_g_nxt;
  logic signed [SUM_W-1:0] sum_b_nxt;

  always_comb begin
    base      = $signed({3'b000, luma, 16'h0000});
    sum_r_nxt = base + chroma.prod_rv;
    sum_g_nxt = base - chroma.prod_gv - chroma.prod_gu;
    sum_b_nxt = base + chroma.prod_bu;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r_r <= sum_r_nxt;
      sum_g_r <= sum_g_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  always_comb begin
    pixel.red   = finish_channel(sum_r_r);
    pixel.green = finish_channel(sum_g_r);
    pixel.blue  = finish_channel(sum_b_r);
  end

endmodule

// ===== hdl/yuyv_to_rgb24_converter.sv =====
// Path: accepted input goes through the chroma, lane and output registers.
// Throughput: one transaction per cycle; two pixel lanes share one chroma
// multiply stage, and a 3-stage elastic pipeline stalls only when full.
// Reset: rst_n synchronous, active low; clears the stage valid bits only,
// payload registers are not reset.
`include "assert_macros.svh"

module yuyv_to_rgb24_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  yrc_pkg::yrc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output yrc_pkg::yrc_out_t out_data
);
  import yrc_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        s2_valid_r;
  logic        s2_valid_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        s2_fe_r;
  logic        ready_s1;
  logic        ready_s2;
  logic        ready_out;
  yrc_chroma_t chroma;
  yrc_rgb_t    pix_first;
  yrc_rgb_t    pix_second;
  yrc_out_t    out_data_r;
  yrc_out_t    out_data_nxt;

  assign ready_out = !out_valid_r || !out_stall;
  assign ready_s2  = !s2_valid_r || ready_out;
  assign ready_s1  = !s1_valid_r || ready_s2;

  yrc_chroma u_chroma (
    .clk     (clk),
    .en      (ready_s1),
    .in_data (in_data),
    .chroma  (chroma)
  );

  yrc_lane u_lane_first (
    .clk    (clk),
    .en     (ready_s2),
    .luma   (chroma.luma_first),
    .chroma (chroma),
    .pixel  (pix_first)
  );

  yrc_lane u_lane_second (
    .clk    (clk),
    .en     (ready_s2),
    .luma   (chroma.luma_second),
    .chroma (chroma),
    .pixel  (pix_second)
  );

  always_comb begin
    s1_valid_nxt  = ready_s1 ? in_valid : s1_valid_r;
    s2_valid_nxt  = ready_s2 ? s1_valid_r : s2_valid_r;
    out_valid_nxt = ready_out ? s2_valid_r : out_valid_r;
    out_data_nxt.red_first     = pix_first.red;
    out_data_nxt.green_first   = pix_first.green;
    out_data_nxt.blue_first    = pix_first.blue;
    out_data_nxt.red_second    = pix_second.red;
    out_data_nxt.green_second  = pix_second.green;
    out_data_nxt.blue_second   = pix_second.blue;
    out_data_nxt.frame_end_out = s2_fe_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_s2) begin
      s2_fe_r <= chroma.frame_end;
    end
    if (ready_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign in_stall  = !ready_s1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_PROP(a_stall_only_when_full, in_stall |-> (out_valid && out_stall),
               "input stalled while pipeline has room")
  `ASSERT_PROP(a_latency,
               (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid,
               "accepted transaction did not reach output in 3 cycles")
  `ASSERT_NEVER(a_range_first,
                out_valid && (out_data.red_first > CHAN_MAX ||
                out_data.green_first > CHAN_MAX || out_data.blue_first > CHAN_MAX),
                "first pixel channel above scaled maximum")
  `ASSERT_NEVER(a_range_second,
                out_valid && (out_data.red_second > CHAN_MAX ||
                out_data.green_second > CHAN_MAX || out_data.blue_second > CHAN_MAX),
                "second pixel channel above scaled maximum")

endmodule
